[sv/prev_encoding_stream_unit_macros.svh]
// assertion macros shared by the prev encoding stream unit
`ifndef PREV_ENCODING_STREAM_UNIT_MACROS_SVH
`define PREV_ENCODING_STREAM_UNIT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define PES_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define PES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/pes_pkg.sv]
// package: constants, payload types and symbol folding table for the prev encoder
package pes_pkg;

    // string and alphabet limits
    localparam int MAX_LEN = 4096;
    localparam int SYMBOLS = 256;

    // internal widths follow from the limits
    localparam int SYM_W = $clog2(SYMBOLS);
    localparam int POS_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    // fixed field widths of the result
    localparam int BYTE_W = 8;
    localparam int CODE_W = 12;
    localparam int LEN_W  = 13;
    localparam int KIND_W = 2;

    // string class codes
    localparam logic [KIND_W-1:0] KIND_ALL_ZERO      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PREFIX_LONGER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OTHER         = 2'd2;

    // input request
    typedef struct packed {
        logic [BYTE_W-1:0] symbol;
        logic              last_symbol;
    } t_in_item;

    // result
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] position;
        logic              end_of_string;
        logic [LEN_W-1:0]  string_length;
        logic [LEN_W-1:0]  zero_prefix_len;
        logic [CODE_W-1:0] first_nonzero;
        logic [KIND_W-1:0] kind;
        logic              overflow;
    } t_out_item;

    // request as seen by the encode stage, last position already resolved
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
        logic [POS_W-1:0] lpos;
    } t_enc_req;

    // write back to the last-position memory
    typedef struct packed {
        logic             en;
        logic [SYM_W-1:0] addr;
        logic [POS_W-1:0] data;
    } t_mem_wr;

    // byte value folded onto the alphabet, worked out at elaboration
    localparam int BYTE_VALUES = 2 ** BYTE_W;
    typedef logic [BYTE_VALUES-1:0][SYM_W-1:0] t_fold_tab;

    function automatic t_fold_tab make_fold_tab();
        t_fold_tab tab;
        for (int i = 0; i < BYTE_VALUES; i++) begin
            tab[i] = SYM_W'(i % SYMBOLS);
        end
        return tab;
    endfunction

    localparam t_fold_tab FOLD_TAB = make_fold_tab();

endpackage

[sv/pes_lpos_ram.sv]
// generic single write, single read port ram with registered read data
module pes_lpos_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 12
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/pes_encode_core.sv]
// encode stage: seen flags, string counters, code and summary generation
`include "prev_encoding_stream_unit_macros.svh"

module pes_encode_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  pes_pkg::t_enc_req  i_req,
    output pes_pkg::t_mem_wr   o_wr,
    output pes_pkg::t_out_item o_result
);
    import pes_pkg::*;

    logic [SYMBOLS-1:0] r_seen,       n_seen;
    logic [CNT_W-1:0]   r_pos_cnt,    n_pos_cnt;
    logic [CNT_W-1:0]   r_zero_cnt,   n_zero_cnt;
    logic               r_repeat,     n_repeat;
    logic [POS_W-1:0]   r_first,      n_first;
    logic               r_overflow,   n_overflow;

    logic               full;
    logic               hit;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   diff;
    logic [CNT_W-1:0]   fnz_ext;

    // lookups on the current string state
    assign full = (r_pos_cnt == CNT_W'(MAX_LEN));
    assign pos  = r_pos_cnt[POS_W-1:0];
    assign hit  = r_seen[i_req.sym];
    assign diff = pos - i_req.lpos;

    // next state, write back and result
    always_comb begin
        n_seen     = r_seen;
        n_pos_cnt  = r_pos_cnt;
        n_zero_cnt = r_zero_cnt;
        n_repeat   = r_repeat;
        n_first    = r_first;
        n_overflow = r_overflow;
        o_wr       = '0;
        o_result   = '0;
        fnz_ext    = '0;
        if (i_fire) begin
            if (full) begin
                n_overflow = 1'b1;
            end else begin
                if (hit) begin
                    o_result.code = CODE_W'(diff);
                    if (!r_repeat) begin
                        n_repeat = 1'b1;
                        n_first  = diff;
                    end
                end else if (!r_repeat) begin
                    n_zero_cnt = r_zero_cnt + CNT_W'(1);
                end
                n_seen[i_req.sym] = 1'b1;
                n_pos_cnt         = r_pos_cnt + CNT_W'(1);
                o_wr.en           = 1'b1;
                o_wr.addr         = i_req.sym;
                o_wr.data         = pos;
                o_result.position = CODE_W'(pos);
            end
            o_result.overflow = n_overflow;

            // summary on the final byte, then a fresh string
            if (i_req.last) begin
                fnz_ext                  = CNT_W'(n_first);
                o_result.end_of_string   = 1'b1;
                o_result.string_length   = LEN_W'(n_pos_cnt);
                o_result.zero_prefix_len = LEN_W'(n_zero_cnt);
                o_result.first_nonzero   = CODE_W'(n_first);
                priority if (n_zero_cnt == n_pos_cnt) begin
                    o_result.kind = KIND_ALL_ZERO;
                end else if (n_zero_cnt > fnz_ext) begin
                    o_result.kind = KIND_PREFIX_LONGER;
                end else begin
                    o_result.kind = KIND_OTHER;
                end
                n_seen     = '0;
                n_pos_cnt  = '0;
                n_zero_cnt = '0;
                n_repeat   = 1'b0;
                n_first    = '0;
                n_overflow = 1'b0;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_pos_cnt  <= '0;
            r_zero_cnt <= '0;
            r_repeat   <= 1'b0;
            r_first    <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_seen     <= n_seen;
            r_pos_cnt  <= n_pos_cnt;
            r_zero_cnt <= n_zero_cnt;
            r_repeat   <= n_repeat;
            r_first    <= n_first;
            r_overflow <= n_overflow;
        end
    end

    // counter and first code consistency
    `PES_ASSERT_ALWAYS(a_pos_in_range, i_clk, i_rst_n, r_pos_cnt <= CNT_W'(MAX_LEN), "position count beyond limit")
    `PES_ASSERT_ALWAYS(a_zero_le_pos, i_clk, i_rst_n, r_zero_cnt <= r_pos_cnt, "zero prefix longer than string")
    `PES_ASSERT_ALWAYS(a_first_needs_repeat, i_clk, i_rst_n, r_repeat || (r_first == '0), "first code set without a repeat")

endmodule

[sv/prev_encoding_stream_unit.sv]
// top level: request stage with memory read and forwarding, encode stage, output register
//
// Streaming prev encoder. Each request carries one byte and a last flag; each
// byte yields one result: 0 on its first occurrence in the string, otherwise
// the distance back to its most recent occurrence, with its position.
// The result for the last byte also carries the string length, zero prefix
// length, first nonzero code and class, after which a new string starts.
// Bytes beyond MAX_LEN are not encoded; they return code 0 and set overflow.
// An accepted request waits in the encode stage register, then its result in
// the output register until taken. Throughput: one byte per cycle while
// results are taken; the last-position memory is read on accept and written
// when the byte leaves the encode stage, with a bypass for back to back equal
// bytes. The output register decouples the sides: a new request is taken
// while a result waits, and a stall holds the result and then the encode
// stage, at which point ready drops until the result is taken.
// Reset (synchronous, active low) empties the pipeline and clears the seen
// flags and counters at once; the memory itself needs no clearing.
`include "prev_encoding_stream_unit_macros.svh"

module prev_encoding_stream_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pes_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pes_pkg::t_out_item o_out_item
);
    import pes_pkg::*;

    logic             r_s1_valid;
    logic [SYM_W-1:0] r_s1_sym;
    logic             r_s1_last;
    logic             r_fwd;
    logic [POS_W-1:0] r_fwd_pos;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic             s1_go;
    logic             s1_fire;
    logic             in_acc;
    logic [SYM_W-1:0] in_sym;
    logic [POS_W-1:0] rd_data;
    t_enc_req         enc_req;
    t_mem_wr          wr;
    t_out_item        result;

    // handshake
    assign s1_go      = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && s1_go;
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_sym     = FOLD_TAB[i_in_item.symbol];

    // last-position memory
    pes_lpos_ram #(
        .DEPTH (SYMBOLS),
        .WIDTH (POS_W)
    ) u_lpos_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr.en),
        .i_wr_addr (wr.addr),
        .i_wr_data (wr.data),
        .i_rd_en   (in_acc),
        .i_rd_addr (in_sym),
        .o_rd_data (rd_data)
    );

    // bypass when the previous byte wrote the entry being read
    always_comb begin
        enc_req.sym  = r_s1_sym;
        enc_req.last = r_s1_last;
        enc_req.lpos = r_fwd ? r_fwd_pos : rd_data;
    end

    pes_encode_core u_encode_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s1_fire),
        .i_req    (enc_req),
        .o_wr     (wr),
        .o_result (result)
    );

    // encode stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
            r_fwd      <= wr.en && (wr.addr == in_sym);
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end
    end

    // encode stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sym  <= in_sym;
            r_s1_last <= i_in_item.last_symbol;
            r_fwd_pos <= wr.data;
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // pipeline bookkeeping
    `PES_ASSERT_ALWAYS(a_fwd_needs_stage, i_clk, i_rst_n, !r_fwd || r_s1_valid, "bypass flag without a byte in the encode stage")
    `PES_ASSERT_NEXT(a_accept_fills_stage, i_clk, i_rst_n, in_acc, r_s1_valid, "accepted request missing from encode stage")
    `PES_ASSERT_NEXT(a_fire_fills_output, i_clk, i_rst_n, s1_fire, r_out_valid, "encoded byte missing from output register")

endmodule

[tb/tb_prev_encoding_stream_unit.sv]
// testbench for the prev encoding stream unit: directed strings, long and wide strings, random traffic
module tb_prev_encoding_stream_unit;

    import pes_pkg::*;

    // generous ceiling: every request waiting out the longest gap and the longest stall
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 650;
    localparam int DRAIN_CYCLES = 8;
    localparam int DIR_ROWS     = 22;

    // one directed request with its typed-in result where it is obvious
    typedef struct packed {
        logic [BYTE_W-1:0] symbol;
        logic              last_symbol;
        logic              typed;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] position;
        logic              end_of_string;
        logic [LEN_W-1:0]  string_length;
        logic [LEN_W-1:0]  zero_prefix_len;
        logic [CODE_W-1:0] first_nonzero;
        logic [KIND_W-1:0] kind;
        logic              overflow;
    } t_dir_row;

    //  symbol last typed code pos eos len zlen fnz kind ovf
    localparam t_dir_row DIR_ROWS_TAB [DIR_ROWS] = '{
        // single byte string
        '{8'h00, 1, 1, 0, 0, 1, 1, 1, 0, KIND_ALL_ZERO, 0},
        // top byte value twice
        '{8'hFF, 0, 1, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0},
        '{8'hFF, 1, 1, 1, 1, 1, 2, 1, 1, KIND_OTHER, 0},
        // zero prefix longer than the first distance
        '{8'h55, 0, 0, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0},
        '{8'hAA, 0, 0, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0},
        '{8'h01, 0, 0, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0},
        '{8'h80, 0, 0, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0},
        '{8'h01, 1, 1, 2, 4, 1, 5, 4, 2, KIND_PREFIX_LONGER, 0},
        // new bytes after the first repeat leave the prefix alone
        '{8'h7F, 0, 0, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0},
        '{8'h7F, 0, 0, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0},
        '{8'hFE, 0, 0, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0},
        '{8'h7F, 1, 0, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0},
        // prefix equal to the first distance
        '{8'h12, 0, 0, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0},
        '{8'h34, 0, 0, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0},
        '{8'h56, 0, 0, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0},
        '{8'h12, 1, 0, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0},
        // no repeat at all
        '{8'h01, 0, 0, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0},
        '{8'h02, 0, 0, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0},
        '{8'h04, 1, 1, 0, 2, 1, 3, 3, 0, KIND_ALL_ZERO, 0},
        // back to back equal bytes
        '{8'hC3, 0, 0, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0},
        '{8'hC3, 0, 0, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0},
        '{8'hC3, 1, 0, 0, 0, 0, 0, 0, 0, KIND_ALL_ZERO, 0}
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    // typed-in result travelling with the current request
    logic      row_typed;
    t_out_item row_want;

    // mirror of the encoder state
    logic [POS_W-1:0] last_seen_at [SYMBOLS];
    bit               byte_seen [SYMBOLS];
    int unsigned      string_pos;
    int unsigned      zero_run;
    bit               repeat_found;
    logic [CODE_W-1:0] first_distance;
    bit               string_too_long;

    t_out_item   encodings_due [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned cycle_count;

    prev_encoding_stream_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // start of a new string
    function automatic void clear_string();
        for (int s = 0; s < SYMBOLS; s++) begin
            byte_seen[s] = 1'b0;
        end
        string_pos      = 0;
        zero_run        = 0;
        repeat_found    = 1'b0;
        first_distance  = '0;
        string_too_long = 1'b0;
    endfunction

    // prev code of one byte, with the string summary on the last one
    function automatic t_out_item encode_symbol(input t_in_item req);
        t_out_item   res;
        int unsigned sym;
        res = '0;
        sym = req.symbol % SYMBOLS;
        if (string_pos >= MAX_LEN) begin
            string_too_long = 1'b1;
        end else begin
            if (byte_seen[sym]) begin
                res.code = CODE_W'(string_pos - last_seen_at[sym]);
                if (!repeat_found) begin
                    repeat_found   = 1'b1;
                    first_distance = res.code;
                end
            end else if (!repeat_found) begin
                zero_run++;
            end
            last_seen_at[sym] = POS_W'(string_pos);
            byte_seen[sym]    = 1'b1;
            res.position      = CODE_W'(string_pos);
            string_pos++;
        end
        res.overflow = string_too_long;
        if (req.last_symbol) begin
            res.end_of_string   = 1'b1;
            res.string_length   = LEN_W'(string_pos);
            res.zero_prefix_len = LEN_W'(zero_run);
            res.first_nonzero   = repeat_found ? first_distance : '0;
            if (zero_run == string_pos) begin
                res.kind = KIND_ALL_ZERO;
            end else if (zero_run > res.first_nonzero) begin
                res.kind = KIND_PREFIX_LONGER;
            end else begin
                res.kind = KIND_OTHER;
            end
            clear_string();
        end
        return res;
    endfunction

    function automatic void note_mismatch(input string field, input logic [15:0] want,
                                          input logic [15:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("result %0d: %s expected %0h, got %0h", results_seen, field, want, got);
        end
    endfunction

    // idle length: none in a burst, otherwise mostly none or short, now and then long
    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // track accepted requests and check accepted results
    always @(posedge i_clk) begin : scoreboard
        t_out_item want;
        t_out_item got;
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                want = encode_symbol(i_in_item);
                if (row_typed) begin
                    want = row_want;
                end
                encodings_due.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                got = o_out_item;
                if (encodings_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d arrived with nothing pending: %p", results_seen, got);
                    end
                end else begin
                    want = encodings_due.pop_front();
                    if (got.code !== want.code)
                        note_mismatch("code", 16'(want.code), 16'(got.code));
                    if (got.position !== want.position)
                        note_mismatch("position", 16'(want.position), 16'(got.position));
                    if (got.end_of_string !== want.end_of_string)
                        note_mismatch("end_of_string", 16'(want.end_of_string),
                                      16'(got.end_of_string));
                    if (got.string_length !== want.string_length)
                        note_mismatch("string_length", 16'(want.string_length),
                                      16'(got.string_length));
                    if (got.zero_prefix_len !== want.zero_prefix_len)
                        note_mismatch("zero_prefix_len", 16'(want.zero_prefix_len),
                                      16'(got.zero_prefix_len));
                    if (got.first_nonzero !== want.first_nonzero)
                        note_mismatch("first_nonzero", 16'(want.first_nonzero),
                                      16'(got.first_nonzero));
                    if (got.kind !== want.kind)
                        note_mismatch("kind", 16'(want.kind), 16'(got.kind));
                    if (got.overflow !== want.overflow)
                        note_mismatch("overflow", 16'(want.overflow), 16'(got.overflow));
                end
                results_seen++;
            end
        end
    end

    // result side: random stalls, occasional long stretches always ready
    initial begin : result_sink
        int calm_left;
        int stall_left;
        int r;
        calm_left  = 0;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm_left > 0) begin
                calm_left--;
                i_out_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    calm_left = $urandom_range(20, 80);
                    i_out_ready <= 1'b1;
                end else if (r < 50) begin
                    stall_left = pick_gap(1'b0);
                    i_out_ready <= (stall_left == 0);
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    // one request: optional gap, then hold until taken; entered and left at a falling edge
    task automatic drive_request(input logic [BYTE_W-1:0] sym, input logic last,
                                 input logic typed, input t_out_item want, input bit burst);
        int gap;
        gap = pick_gap(burst);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid            <= 1'b1;
        i_in_item.symbol      <= sym;
        i_in_item.last_symbol <= last;
        row_typed             <= typed;
        row_want              <= want;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // hold requests back until every result is home; entered and left at a falling edge
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (encodings_due.size() != 0);
    endtask

    // stimulus
    initial begin : stimulus
        t_dir_row        row;
        t_out_item       want;
        logic [BYTE_W-1:0] sym;
        logic [BYTE_W-1:0] perm [SYMBOLS];
        logic [BYTE_W-1:0] pool [8];
        logic [BYTE_W-1:0] tmp;
        int              sent;
        int              len;
        int              pool_size;
        int              j;
        bit              burst;
        bit              narrow;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        row_typed   <= 1'b0;
        row_want    <= '0;
        mismatches   = 0;
        results_seen = 0;
        cycle_count  = 0;
        for (int s = 0; s < SYMBOLS; s++) begin
            last_seen_at[s] = '0;
        end
        clear_string();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed strings
        for (int k = 0; k < DIR_ROWS; k++) begin
            row  = DIR_ROWS_TAB[k];
            want = '{code: row.code, position: row.position, end_of_string: row.end_of_string,
                     string_length: row.string_length, zero_prefix_len: row.zero_prefix_len,
                     first_nonzero: row.first_nonzero, kind: row.kind,
                     overflow: row.overflow};
            drive_request(row.symbol, row.last_symbol, row.typed, want, k[0]);
        end
        wait_drained();

        // longest distance, then bytes past the length limit with the last among them
        drive_request(8'hAB, 1'b0, 1'b0, '0, 1'b1);
        for (int p = 1; p < MAX_LEN - 1; p++) begin
            sym = BYTE_W'($urandom_range(0, 254));
            if (sym >= 8'hAB) begin
                sym++;
            end
            drive_request(sym, 1'b0, 1'b0, '0, ($urandom_range(0, 9) != 0));
        end
        drive_request(8'hAB, 1'b0, 1'b0, '0, 1'b0);
        for (int p = 0; p < 3; p++) begin
            drive_request(BYTE_W'($urandom_range(0, 255)), p == 2, 1'b0, '0, 1'b0);
        end

        // every byte value once, then a repeat: longest zero prefix
        for (int s = 0; s < SYMBOLS; s++) begin
            perm[s] = BYTE_W'(s);
        end
        for (int s = SYMBOLS - 1; s > 0; s--) begin
            j       = $urandom_range(0, s);
            tmp     = perm[s];
            perm[s] = perm[j];
            perm[j] = tmp;
        end
        for (int s = 0; s < SYMBOLS; s++) begin
            drive_request(perm[s], 1'b0, 1'b0, '0, 1'b0);
        end
        drive_request(perm[$urandom_range(0, SYMBOLS - 1)], 1'b1, 1'b0, '0, 1'b0);
        wait_drained();

        // random strings: mostly short, some drawn from small alphabets for frequent repeats
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            j = $urandom_range(0, 99);
            if (j < 70) begin
                len = $urandom_range(1, 12);
            end else if (j < 95) begin
                len = $urandom_range(13, 60);
            end else begin
                len = $urandom_range(61, 300);
            end
            burst     = ($urandom_range(0, 4) == 0);
            narrow    = ($urandom_range(0, 1) == 1);
            pool_size = $urandom_range(1, 8);
            for (int s = 0; s < 8; s++) begin
                pool[s] = BYTE_W'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 19) == 0) begin
                wait_drained();
            end
            for (int p = 0; p < len; p++) begin
                if (narrow) begin
                    sym = pool[$urandom_range(0, pool_size - 1)];
                end else begin
                    sym = BYTE_W'($urandom_range(0, 255));
                end
                drive_request(sym, p == len - 1, 1'b0, '0, burst);
            end
            sent += len;
        end

        // let the pipeline empty
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
